// File: hw/rtl/dust_density_moving_average_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dust density moving average unit
// Shared assertion forms, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef DUST_DENSITY_MOVING_AVERAGE_UNIT_MACROS_SVH
`define DUST_DENSITY_MOVING_AVERAGE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/ddma_pkg.sv
// ----------------------------------------------------------------------------
// Dust density moving average package
// Field widths, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ddma_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int VOLT_W     = 28;
    localparam int DENS_W     = 36;
    localparam int MV_W       = 16;
    localparam int THR_W      = 13;
    localparam int DPM_W      = 16;
    localparam int FRAC_W     = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = SAMPLE_W + VOLT_W + DENS_W;
    localparam int M_TDATA_W  = 80;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;
    localparam int S_PAD_W    = S_TDATA_W - SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_MV_PER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_AIR_MV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY_PER_MV = 2'd2;

    localparam logic [MV_W-1:0]  MV_PER_COUNT_RST   = 16'd312;
    localparam logic [THR_W-1:0] CLEAN_AIR_MV_RST   = 13'd400;
    localparam logic [DPM_W-1:0] DENSITY_PER_MV_RST = 16'd51;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_VOLT = 7'b0001000,
        ST_DIFF = 7'b0010000,
        ST_DENS = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dust_density_moving_average_unit.sv
// ----------------------------------------------------------------------------
// Dust density moving average unit
// Boxcar average of converter samples, voltage scaling and density mapping.
// ----------------------------------------------------------------------------
// Each accepted item runs through the READ, DIV, VOLT, DIFF and DENS states
// and then waits in DONE until its result is loaded into the output register,
// and s_tready stays low until then, so the next item is accepted in the idle
// state only after the last result has been loaded into the output register.
// A single 28 by 18 bit multiplier (for the default window) is used three
// times per item: for the division by WINDOW through a reciprocal, for the
// voltage scaling and for the density ratio, which sets the length of the
// sequence. The sample window lives in a small RAM. The first sample after
// reset or after a sensor error is held as a fill value that stands for
// every entry not yet overwritten, so no clearing pass is needed.
`default_nettype none

`include "dust_density_moving_average_unit_macros.svh"

module dust_density_moving_average_unit #(
    parameter int WINDOW = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // s_tdata: raw_sample[11:0], zero padding above.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ddma_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: filtered_value[11:0], voltage_q8[39:12], density_q8[75:40].
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ddma_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: sensor_error[0].
    output logic      [0:0]                     m_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [ddma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ddma_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HEAD_W  = $clog2(WINDOW);
    localparam int SUM_W   = ddma_pkg::SAMPLE_W + HEAD_W;
    localparam int SHIFT   = SUM_W + HEAD_W;
    localparam int RECIP   = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int MUL_A_W = ddma_pkg::VOLT_W;
    localparam int MUL_B_W = (SHIFT > ddma_pkg::MV_W) ? SHIFT : ddma_pkg::MV_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_MAX = WINDOW * ((1 << ddma_pkg::SAMPLE_W) - 1);

    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW - 1);

    ddma_pkg::state_t state_reg, state_next;

    logic [ddma_pkg::MV_W-1:0]     mv_reg;
    logic [ddma_pkg::THR_W-1:0]    thr_reg;
    logic [ddma_pkg::DPM_W-1:0]    dpm_reg;

    logic                          primed_reg, primed_next;
    logic                          wrapped_reg, wrapped_next;
    logic [HEAD_W-1:0]             head_reg, head_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    logic [ddma_pkg::SAMPLE_W-1:0] sample_reg;
    logic [ddma_pkg::SAMPLE_W-1:0] prime_val_reg, prime_val_next;
    logic [PROD_W-1:0]             prod_reg;
    logic [ddma_pkg::SAMPLE_W-1:0] filt_reg;
    logic [ddma_pkg::VOLT_W-1:0]   volt_reg;
    logic [ddma_pkg::VOLT_W-1:0]   diff_reg;
    logic                          err_reg;
    logic                          above_reg;
    logic [ddma_pkg::SAMPLE_W-1:0] m_filt_reg;
    logic [ddma_pkg::VOLT_W-1:0]   m_volt_reg;
    logic [ddma_pkg::DENS_W-1:0]   m_dens_reg;
    logic                          m_err_reg;

    logic                          in_accept;
    logic                          out_load;
    logic                          ram_we;
    logic [ddma_pkg::SAMPLE_W-1:0] ram_rdata;
    logic [ddma_pkg::SAMPLE_W-1:0] oldest;
    logic [MUL_A_W-1:0]            mul_a;
    logic [MUL_B_W-1:0]            mul_b;
    logic [PROD_W-1:0]             prod;
    logic [ddma_pkg::VOLT_W-1:0]   volt;
    logic [ddma_pkg::VOLT_W-1:0]   thr_q;
    logic [ddma_pkg::DENS_W-1:0]   dens;

    ddma_ram #(
        .WIDTH (ddma_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (sample_reg),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ddma_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ddma_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    assign oldest    = wrapped_reg ? ram_rdata : prime_val_reg;
    assign volt      = prod_reg[ddma_pkg::VOLT_W-1:0];
    assign thr_q     = ddma_pkg::VOLT_W'({thr_reg, {ddma_pkg::FRAC_W{1'b0}}});
    assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign dens      = (above_reg && !err_reg) ?
                       prod_reg[ddma_pkg::FRAC_W +: ddma_pkg::DENS_W] : '0;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ddma_pkg::ST_DIV:
            begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(RECIP);
            end
            ddma_pkg::ST_VOLT:
            begin
                mul_a = MUL_A_W'(prod_reg[SHIFT +: ddma_pkg::SAMPLE_W]);
                mul_b = MUL_B_W'(mv_reg);
            end
            ddma_pkg::ST_DENS:
            begin
                mul_a = diff_reg;
                mul_b = MUL_B_W'(dpm_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        primed_next    = primed_reg;
        wrapped_next   = wrapped_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        prime_val_next = prime_val_reg;
        ram_we         = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ddma_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ddma_pkg::ST_READ;
                end
            end
            ddma_pkg::ST_READ:
            begin
                if (!primed_reg)
                begin
                    sum_next       = SUM_W'(sample_reg) * SUM_W'(WINDOW);
                    prime_val_next = sample_reg;
                    primed_next    = 1'b1;
                    head_next      = '0;
                    wrapped_next   = 1'b0;
                end
                else
                begin
                    sum_next     = sum_reg - SUM_W'(oldest) + SUM_W'(sample_reg);
                    ram_we       = 1'b1;
                    head_next    = (head_reg == HEAD_LAST) ? '0 : head_reg + HEAD_W'(1);
                    wrapped_next = wrapped_reg || (head_reg == HEAD_LAST);
                end
                state_next = ddma_pkg::ST_DIV;
            end
            ddma_pkg::ST_DIV:
            begin
                state_next = ddma_pkg::ST_VOLT;
            end
            ddma_pkg::ST_VOLT:
            begin
                state_next = ddma_pkg::ST_DIFF;
            end
            ddma_pkg::ST_DIFF:
            begin
                state_next = ddma_pkg::ST_DENS;
            end
            ddma_pkg::ST_DENS:
            begin
                state_next = ddma_pkg::ST_DONE;
            end
            ddma_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ddma_pkg::ST_IDLE;
                    if (err_reg)
                    begin
                        primed_next  = 1'b0;
                        wrapped_next = 1'b0;
                        head_next    = '0;
                        sum_next     = '0;
                    end
                end
            end
            default:
            begin
                state_next = ddma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ddma_pkg::ST_IDLE;
            primed_reg   <= 1'b0;
            wrapped_reg  <= 1'b0;
            head_reg     <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            mv_reg       <= ddma_pkg::MV_PER_COUNT_RST;
            thr_reg      <= ddma_pkg::CLEAN_AIR_MV_RST;
            dpm_reg      <= ddma_pkg::DENSITY_PER_MV_RST;
        end
        else
        begin
            state_reg    <= state_next;
            primed_reg   <= primed_next;
            wrapped_reg  <= wrapped_next;
            head_reg     <= head_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ddma_pkg::REG_MV_PER_COUNT:   mv_reg  <= cfg_wdata[ddma_pkg::MV_W-1:0];
                    ddma_pkg::REG_CLEAN_AIR_MV:   thr_reg <= cfg_wdata[ddma_pkg::THR_W-1:0];
                    ddma_pkg::REG_DENSITY_PER_MV: dpm_reg <= cfg_wdata[ddma_pkg::DPM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prime_val_reg <= prime_val_next;
        if (in_accept)
        begin
            sample_reg <= s_tdata[ddma_pkg::SAMPLE_W-1:0];
        end
        if ((state_reg == ddma_pkg::ST_DIV) || (state_reg == ddma_pkg::ST_VOLT) ||
            (state_reg == ddma_pkg::ST_DENS))
        begin
            prod_reg <= prod;
        end
        if (state_reg == ddma_pkg::ST_VOLT)
        begin
            filt_reg <= prod_reg[SHIFT +: ddma_pkg::SAMPLE_W];
        end
        if (state_reg == ddma_pkg::ST_DIFF)
        begin
            volt_reg  <= volt;
            diff_reg  <= volt - thr_q;
            err_reg   <= (volt == '0);
            above_reg <= (volt >= thr_q);
        end
        if (out_load)
        begin
            m_filt_reg <= filt_reg;
            m_volt_reg <= volt_reg;
            m_dens_reg <= dens;
            m_err_reg  <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{ddma_pkg::M_PAD_W{1'b0}}, m_dens_reg, m_volt_reg, m_filt_reg};
    assign m_tuser  = m_err_reg;

    `ASSERT_NEXT(a_accept_starts_read, clk, rst_n, in_accept, state_reg == ddma_pkg::ST_READ)
    `ASSERT_IMPLIES(a_result_from_done, clk, rst_n, m_tvalid_reg && !$past(m_tvalid_reg), $past(state_reg) == ddma_pkg::ST_DONE)
    `ASSERT_IMPLIES(a_error_zero_density, clk, rst_n, m_tvalid_reg && m_err_reg, m_dens_reg == '0)
    `ASSERT_ALWAYS(a_sum_bounded, clk, rst_n, sum_reg <= SUM_W'(SUM_MAX))
    `ASSERT_IMPLIES(a_unprimed_sum_zero, clk, rst_n, !primed_reg, sum_reg == '0 && !wrapped_reg)

endmodule

`default_nettype wire

// File: hw/rtl/ddma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: bench/dust_density_moving_average_unit_test.sv
// ----------------------------------------------------------------------------
// Dust density moving average unit testbench
// Streams converter samples through the unit under random source gaps and
// sink stalls, and checks every output item field by field. The checker
// holds its own copy of the averaging window and of the scale registers, and
// it forms the expected item for each accepted sample. A directed opening
// covers priming, zero voltage, the threshold edge and the register
// extremes. Random phases with fresh register settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module dust_density_moving_average_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN     = 8;
    localparam int WIN_LOG = 3;

    localparam logic [ddma_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ddma_pkg::SAMPLE_W-1:0] filtered_value;
        logic [ddma_pkg::VOLT_W-1:0]   voltage_q8;
        logic [ddma_pkg::DENS_W-1:0]   density_q8;
        logic                          sensor_error;
    } reading_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ddma_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ddma_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                      m_tuser;
    logic                            cfg_we = 1'b0;
    logic [ddma_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ddma_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    dust_density_moving_average_unit #(
        .WINDOW(WIN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    logic [ddma_pkg::MV_W-1:0]             mv_scale = ddma_pkg::MV_PER_COUNT_RST;
    logic [ddma_pkg::THR_W-1:0]            clean_thr = ddma_pkg::CLEAN_AIR_MV_RST;
    logic [ddma_pkg::DPM_W-1:0]            dens_ratio = ddma_pkg::DENSITY_PER_MV_RST;
    logic [ddma_pkg::SAMPLE_W-1:0]         ring [WIN];
    logic [ddma_pkg::SAMPLE_W+WIN_LOG-1:0] ring_sum = '0;
    logic [WIN_LOG-1:0]                    ring_head = '0;
    logic                                  ring_full = 1'b0;

    logic [ddma_pkg::SAMPLE_W-1:0] sample_feed [$];
    reading_t                      predicted_readings [$];
    int                            fail_count = 0;
    bit                            gaps_on = 1'b1;
    bit                            stalls_on = 1'b1;
    bit                            feed_taken = 1'b0;
    int unsigned                   feed_gap = 0;
    int unsigned                   drain_stall = 0;

    always #2 clk = ~clk;

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic advance_filter(input logic [ddma_pkg::SAMPLE_W-1:0] sample,
                                  output reading_t r);
        logic [ddma_pkg::SAMPLE_W-1:0] filt;
        logic [63:0]                   volt;
        logic [63:0]                   thr;
        logic [63:0]                   dens;
        if (!ring_full)
        begin
            for (int i = 0; i < WIN; i++)
                ring[i] = sample;
            ring_sum = {{WIN_LOG{1'b0}}, sample} << WIN_LOG;
            ring_head = '0;
            ring_full = 1'b1;
            filt = sample;
        end
        else
        begin
            ring_sum = ring_sum - ring[ring_head] + sample;
            ring[ring_head] = sample;
            ring_head = ring_head + 1'b1;
            filt = ddma_pkg::SAMPLE_W'(ring_sum >> WIN_LOG);
        end
        volt = 64'(filt) * 64'(mv_scale);
        thr = 64'(clean_thr) << ddma_pkg::FRAC_W;
        r = '0;
        r.filtered_value = filt;
        r.voltage_q8 = volt[ddma_pkg::VOLT_W-1:0];
        if (volt == 0)
        begin
            r.sensor_error = 1'b1;
            ring_full = 1'b0;
            ring_sum = '0;
            ring_head = '0;
        end
        else if (volt >= thr)
        begin
            dens = ((volt - thr) * 64'(dens_ratio)) >> ddma_pkg::FRAC_W;
            r.density_q8 = dens[ddma_pkg::DENS_W-1:0];
        end
    endtask

    // Source side: present items from the feed and hold each until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !feed_taken)
        begin
        end
        else if (feed_gap > 0)
        begin
            feed_gap = feed_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (sample_feed.size() > 0)
        begin
            s_tdata <= {{ddma_pkg::S_PAD_W{1'b0}}, sample_feed.pop_front()};
            s_tvalid <= 1'b1;
            feed_taken = 1'b0;
            feed_gap = gaps_on ? idle_length() : 0;
        end
        else
            s_tvalid <= 1'b0;
    end

    always @(posedge clk)
    begin
        reading_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            advance_filter(s_tdata[ddma_pkg::SAMPLE_W-1:0], r);
            predicted_readings.push_back(r);
            feed_taken = 1'b1;
        end
    end

    // Sink side: random back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (drain_stall > 0)
        begin
            drain_stall = drain_stall - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 20)
                drain_stall = idle_length();
        end
    end

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.filtered_value = m_tdata[ddma_pkg::SAMPLE_W-1:0];
            got.voltage_q8 = m_tdata[ddma_pkg::SAMPLE_W +: ddma_pkg::VOLT_W];
            got.density_q8 = m_tdata[ddma_pkg::SAMPLE_W+ddma_pkg::VOLT_W +: ddma_pkg::DENS_W];
            got.sensor_error = m_tuser[0];
            if (predicted_readings.size() == 0)
            begin
                $error("output item with none outstanding");
                fail_count++;
            end
            else
            begin
                want = predicted_readings.pop_front();
                if (got.filtered_value !== want.filtered_value)
                begin
                    $error("filtered_value: expected %0d, got %0d",
                           want.filtered_value, got.filtered_value);
                    fail_count++;
                end
                if (got.voltage_q8 !== want.voltage_q8)
                begin
                    $error("voltage_q8: expected %0d, got %0d",
                           want.voltage_q8, got.voltage_q8);
                    fail_count++;
                end
                if (got.density_q8 !== want.density_q8)
                begin
                    $error("density_q8: expected %0d, got %0d",
                           want.density_q8, got.density_q8);
                    fail_count++;
                end
                if (got.sensor_error !== want.sensor_error)
                begin
                    $error("sensor_error: expected %0d, got %0d",
                           want.sensor_error, got.sensor_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic cfg_write(input logic [ddma_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ddma_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            ddma_pkg::REG_MV_PER_COUNT:   mv_scale = val;
            ddma_pkg::REG_CLEAN_AIR_MV:   clean_thr = val[ddma_pkg::THR_W-1:0];
            ddma_pkg::REG_DENSITY_PER_MV: dens_ratio = val;
            default:                      ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Checked at the rising edge, where the source valid has settled.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (sample_feed.size() != 0 || s_tvalid || predicted_readings.size() != 0);
    endtask

    function automatic logic [ddma_pkg::CFG_DATA_W-1:0] cfg_pick();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ddma_pkg::CFG_DATA_W'($urandom_range(1, 16));
            default: return ddma_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly random samples, with runs of zeros that empty the window and
    // runs of small values that sit below the threshold.
    task automatic push_random(input int n);
        int left;
        int len;
        int unsigned r;
        left = n;
        while (left > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                sample_feed.push_back(ddma_pkg::SAMPLE_W'($urandom_range(0, 4095)));
                left--;
            end
            else if (r < 80)
            begin
                case ($urandom_range(0, 3))
                    0:       sample_feed.push_back(12'd0);
                    1:       sample_feed.push_back(12'd4095);
                    2:       sample_feed.push_back(12'd1);
                    default: sample_feed.push_back(12'd2048);
                endcase
                left--;
            end
            else if (r < 88)
            begin
                len = $urandom_range(8, 12);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    sample_feed.push_back(12'd0);
                    left--;
                end
            end
            else
            begin
                len = $urandom_range(4, 10);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    sample_feed.push_back(ddma_pkg::SAMPLE_W'($urandom_range(0, 31)));
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: a zero sample while unprimed, priming at full scale,
        // a decay to zero that clears the window, and values below, then above, threshold.
        sample_feed.push_back(12'd0);
        sample_feed.push_back(12'd4095);
        sample_feed.push_back(12'd4095);
        repeat (8) sample_feed.push_back(12'd0);
        sample_feed.push_back(12'd300);
        sample_feed.push_back(12'd329);
        sample_feed.push_back(12'hAAA);
        sample_feed.push_back(12'h555);
        wait_idle();

        // A zero scale forces the error path even for nonzero samples.
        cfg_write(ddma_pkg::REG_MV_PER_COUNT, 16'd0);
        sample_feed.push_back(12'd4095);
        sample_feed.push_back(12'd1234);
        wait_idle();

        // One millivolt per count and a threshold of 100 give an exact hit.
        cfg_write(ddma_pkg::REG_MV_PER_COUNT, 16'd256);
        cfg_write(ddma_pkg::REG_CLEAN_AIR_MV, 16'd100);
        cfg_write(ddma_pkg::REG_DENSITY_PER_MV, 16'd256);
        sample_feed.push_back(12'd100);
        sample_feed.push_back(12'd99);
        sample_feed.push_back(12'd101);
        wait_idle();

        // Largest settings; the threshold write carries bits above its width.
        cfg_write(ddma_pkg::REG_MV_PER_COUNT, 16'hFFFF);
        cfg_write(ddma_pkg::REG_CLEAN_AIR_MV, 16'hFFFF);
        cfg_write(ddma_pkg::REG_DENSITY_PER_MV, 16'hFFFF);
        sample_feed.push_back(12'd4095);
        sample_feed.push_back(12'd4095);
        sample_feed.push_back(12'd0);
        sample_feed.push_back(12'd4095);
        wait_idle();

        // No threshold and no ratio, then a write to the unused index.
        cfg_write(ddma_pkg::REG_CLEAN_AIR_MV, 16'd0);
        cfg_write(ddma_pkg::REG_DENSITY_PER_MV, 16'd0);
        cfg_write(REG_UNUSED, 16'h5A5A);
        sample_feed.push_back(12'd5);
        sample_feed.push_back(12'd4095);
        wait_idle();

        for (int p = 0; p < 14; p++)
        begin
            cfg_write(ddma_pkg::REG_MV_PER_COUNT, cfg_pick());
            cfg_write(ddma_pkg::REG_CLEAN_AIR_MV, cfg_pick());
            cfg_write(ddma_pkg::REG_DENSITY_PER_MV, cfg_pick());
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_UNUSED, cfg_pick());
            gaps_on = (p % 4 != 3);
            stalls_on = (p % 5 != 2);
            push_random(130);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("dust_density_moving_average_unit: match");
        else
            $display("dust_density_moving_average_unit: mismatch");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("dust_density_moving_average_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
